FILE: design/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the LFU cache: request codes, saturation
// limits and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int CAP_W   = 5;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 32;
    localparam int STAMP_W = 48;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0]  MISS_VALUE = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 32'd1;
    localparam logic [STAMP_W-1:0] STAMP_MAX  = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic start;    // latch request, clear search results
        logic scan_en;  // read the entry at the scan address
        logic commit;   // update state and load the result
    } lfu_cmd_t;

    typedef struct packed {
        logic out_busy; // result register holds a beat that is not taken
    } lfu_status_t;

endpackage

FILE: design/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Request sequencer: accepts a request, sweeps the entry address over all
// slots, drains the last read, then commits the update when out_busy is low.
// ----------------------------------------------------------------------------
module lfu_ctrl #(
    parameter int MAX_ENTRIES = 16,
    parameter int IDX_W       = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lfu_pkg::lfu_status_t status,
    output lfu_pkg::lfu_cmd_t    cmd,
    output logic [IDX_W-1:0]     scan_addr
);
    import lfu_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                // last read is evaluated in this cycle
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign scan_addr = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: design/lfu_dpath.sv
// ----------------------------------------------------------------------------
// lfu_dpath
// Entry storage, the sequential search for key match, free slot and victim,
// the update at commit, the capacity register and the result register.
// ----------------------------------------------------------------------------
module lfu_dpath #(
    parameter int MAX_ENTRIES = 16,
    parameter int IDX_W       = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lfu_pkg::lfu_cmd_t          cmd,
    input  logic [IDX_W-1:0]           scan_addr,
    output lfu_pkg::lfu_status_t       status,
    input  logic                       cfg_valid,
    input  logic [lfu_pkg::CAP_W-1:0]  cfg_data,
    input  logic                       req_action,
    input  logic [lfu_pkg::KEY_W-1:0]  req_key,
    input  logic [lfu_pkg::DATA_W-1:0] req_value,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic                       res_hit,
    output logic [lfu_pkg::DATA_W-1:0] res_read_value,
    output logic                       res_evicted,
    output logic [lfu_pkg::KEY_W-1:0]  res_evicted_key
);
    import lfu_pkg::*;

    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    // entry storage
    logic [KEY_W-1:0]   key_mem   [MAX_ENTRIES];
    logic [DATA_W-1:0]  data_mem  [MAX_ENTRIES];
    logic [COUNT_W-1:0] cnt_mem   [MAX_ENTRIES];
    logic [STAMP_W-1:0] stamp_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;

    logic [KEY_W-1:0]   key_rd;
    logic [DATA_W-1:0]  data_rd;
    logic [COUNT_W-1:0] cnt_rd;
    logic [STAMP_W-1:0] stamp_rd;

    logic [FILL_W-1:0]  fill_reg;
    logic [STAMP_W-1:0] touch_reg;
    logic [CAP_W-1:0]   cap_reg;

    logic               act_reg;
    logic [KEY_W-1:0]   rkey_reg;
    logic [DATA_W-1:0]  rval_reg;

    logic               eval_valid_reg;
    logic [IDX_W-1:0]   eval_idx_reg;

    logic               match_found_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [DATA_W-1:0]  match_data_reg;
    logic [COUNT_W-1:0] match_cnt_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               vic_found_reg;
    logic [IDX_W-1:0]   vic_idx_reg;
    logic [COUNT_W-1:0] vic_cnt_reg;
    logic [STAMP_W-1:0] vic_stamp_reg;
    logic [KEY_W-1:0]   vic_key_reg;

    logic               out_valid_reg;
    logic               hit_reg;
    logic [DATA_W-1:0]  rdval_reg;
    logic               ev_reg;
    logic [KEY_W-1:0]   evkey_reg;

    // search evaluation of the entry read in the previous cycle
    logic ent_valid, is_match, is_free, is_better;

    assign ent_valid = valid_reg[eval_idx_reg];
    assign is_match  = eval_valid_reg && ent_valid && (key_rd == rkey_reg) && !match_found_reg;
    assign is_free   = eval_valid_reg && !ent_valid && !free_found_reg;
    assign is_better = eval_valid_reg && ent_valid &&
                       (!vic_found_reg || (cnt_rd < vic_cnt_reg) ||
                        ((cnt_rd == vic_cnt_reg) && (stamp_rd < vic_stamp_reg)));

    // commit decision
    logic [CMP_W-1:0]   cap_w, max_w, cap_eff, fill_w;
    logic               is_get, do_put, upd, ins, need_evict, ins_ok, wr_en;
    logic [IDX_W-1:0]   ins_dst, wr_idx;
    logic [COUNT_W-1:0] cnt_wr;
    logic [DATA_W-1:0]  data_wr;

    always_comb
    begin
        cap_w      = CMP_W'(cap_reg);
        max_w      = CMP_W'(MAX_ENTRIES);
        cap_eff    = (cap_w > max_w) ? max_w : cap_w;
        fill_w     = CMP_W'(fill_reg);
        is_get     = (act_reg == ACT_GET);
        do_put     = (act_reg == ACT_PUT) && (cap_eff != '0);
        upd        = match_found_reg && (is_get || do_put);
        ins        = do_put && !match_found_reg;
        need_evict = ins && (fill_w >= cap_eff) && vic_found_reg;
        ins_dst    = need_evict ? vic_idx_reg : free_idx_reg;
        ins_ok     = ins && (need_evict || free_found_reg);
        wr_en      = cmd.commit && (upd || ins_ok);
        wr_idx     = upd ? match_idx_reg : ins_dst;
        if (upd)
        begin
            cnt_wr = (match_cnt_reg == COUNT_MAX) ? match_cnt_reg : match_cnt_reg + 1'b1;
        end
        else
        begin
            cnt_wr = COUNT_ONE;
        end
        data_wr = rval_reg;
    end

    assign status.out_busy = out_valid_reg && !out_ready;

    // memories: registered read during the sweep, one write at commit
    always_ff @(posedge clk)
    begin
        if (cmd.scan_en)
        begin
            key_rd   <= key_mem[scan_addr];
            data_rd  <= data_mem[scan_addr];
            cnt_rd   <= cnt_mem[scan_addr];
            stamp_rd <= stamp_mem[scan_addr];
        end
        if (cmd.commit && ins_ok)
        begin
            key_mem[wr_idx] <= rkey_reg;
        end
        if (cmd.commit && (ins_ok || (upd && !is_get)))
        begin
            data_mem[wr_idx] <= data_wr;
        end
        if (wr_en)
        begin
            cnt_mem[wr_idx]   <= cnt_wr;
            stamp_mem[wr_idx] <= touch_reg;
        end
    end

    // request and search payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            act_reg  <= req_action;
            rkey_reg <= req_key;
            rval_reg <= req_value;
        end
        eval_idx_reg <= scan_addr;
        if (is_match)
        begin
            match_idx_reg  <= eval_idx_reg;
            match_data_reg <= data_rd;
            match_cnt_reg  <= cnt_rd;
        end
        if (is_free)
        begin
            free_idx_reg <= eval_idx_reg;
        end
        if (is_better)
        begin
            vic_idx_reg   <= eval_idx_reg;
            vic_cnt_reg   <= cnt_rd;
            vic_stamp_reg <= stamp_rd;
            vic_key_reg   <= key_rd;
        end
        if (cmd.commit)
        begin
            hit_reg   <= match_found_reg;
            rdval_reg <= is_get ? (match_found_reg ? match_data_reg : MISS_VALUE) : '0;
            ev_reg    <= need_evict;
            evkey_reg <= need_evict ? vic_key_reg : '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            fill_reg        <= '0;
            touch_reg       <= '0;
            cap_reg         <= CAP_RESET;
            eval_valid_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            vic_found_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            eval_valid_reg <= cmd.scan_en;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.start)
            begin
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                vic_found_reg   <= 1'b0;
            end
            else
            begin
                if (is_match)
                begin
                    match_found_reg <= 1'b1;
                end
                if (is_free)
                begin
                    free_found_reg <= 1'b1;
                end
                if (is_better)
                begin
                    vic_found_reg <= 1'b1;
                end
            end
            if (wr_en && (touch_reg != STAMP_MAX))
            begin
                touch_reg <= touch_reg + 1'b1;
            end
            // an eviction reuses its slot, so only a fresh slot grows the fill
            if (cmd.commit && ins_ok)
            begin
                valid_reg[wr_idx] <= 1'b1;
                if (!need_evict)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign res_hit         = hit_reg;
    assign res_read_value  = rdval_reg;
    assign res_evicted     = ev_reg;
    assign res_evicted_key = evkey_reg;

endmodule

FILE: design/lfu_cache_replacement_top.sv
// ----------------------------------------------------------------------------
// lfu_cache_replacement_top
// Key-value cache with least-frequently-used replacement, oldest touch first
// among equal counts.
// ----------------------------------------------------------------------------
// A request is taken only while idle; it sweeps the single read port of the
// entry memories, one slot per cycle, and commits once the result register
// is free, before another request is taken.
// The result register lets the next request in while a result waits.
// Reset empties the cache, zeroes the touch clock and sets capacity to 16.
module lfu_cache_replacement_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [4:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic signed [31:0]  lookup_key,
    input  logic signed [31:0]  write_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                hit,
    output logic signed [31:0]  read_value,
    output logic                evicted,
    output logic signed [31:0]  evicted_key
);
    import lfu_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    lfu_cmd_t         cmd;
    lfu_status_t      status;
    logic [IDX_W-1:0] scan_addr;

    assign cfg_ready = 1'b1;

    lfu_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd),
        .scan_addr (scan_addr)
    );

    lfu_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .scan_addr       (scan_addr),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .req_action      (action),
        .req_key         (lookup_key),
        .req_value       (write_value),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .res_hit         (hit),
        .res_read_value  (read_value),
        .res_evicted     (evicted),
        .res_evicted_key (evicted_key)
    );

endmodule
